@@ src/mtcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_pkg
// Shared types and constants for the missing tooth crank/cam sync decoder.
// ----------------------------------------------------------------------------
package mtcs_pkg;

  // Field widths
  localparam int IVL_W = 32;  // tooth interval in timer ticks
  localparam int CNT_W = 7;   // tooth counter
  localparam int CAM_W = 8;   // cam pulse counter

  // Parameter defaults
  localparam int TEETH_PER_REV_DEF = 32;
  localparam int TEETH_TO_LOCK_DEF = 10;

  // Sync state
  typedef enum logic [1:0] {
    SYNC_NONE,
    SYNC_PARTIAL,
    SYNC_FULL
  } sync_state_t;

  // One crank tooth event
  typedef struct packed {
    logic [IVL_W-1:0] tooth_interval;
    logic             cam_edge;
  } tooth_t;

  // One decoder result
  typedef struct packed {
    logic             tooth_accepted;
    logic             is_synced;
    logic             is_semi_synced;
    logic [CNT_W-1:0] tooth_position;
    logic             sync_lost;
  } result_t;

  // Interval compares from the gap detector
  typedef struct packed {
    logic all_valid;  // all three intervals measured
    logic gap;        // long gap at this tooth
    logic overrun;    // current interval above twice the previous one
  } gap_flags_t;

endpackage

@@ src/mtcs_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs interfaces
// Valid/ready channels for tooth events, sync results and configuration.
// ----------------------------------------------------------------------------
interface tooth_if;
  logic                       valid;
  logic                       ready;
  logic [mtcs_pkg::IVL_W-1:0] tooth_interval;
  logic                       cam_edge;

  modport source (output valid, output tooth_interval, output cam_edge, input ready);
  modport sink   (input valid, input tooth_interval, input cam_edge, output ready);
endinterface

interface sync_if;
  logic                       valid;
  logic                       ready;
  logic                       tooth_accepted;
  logic                       is_synced;
  logic                       is_semi_synced;
  logic [mtcs_pkg::CNT_W-1:0] tooth_position;
  logic                       sync_lost;

  modport source (output valid, output tooth_accepted, output is_synced,
                  output is_semi_synced, output tooth_position, output sync_lost,
                  input ready);
  modport sink   (input valid, input tooth_accepted, input is_synced,
                  input is_semi_synced, input tooth_position, input sync_lost,
                  output ready);
endinterface

interface cfg_if;
  logic valid;
  logic ready;
  logic cam_phase_mode;

  modport source (output valid, output cam_phase_mode, input ready);
  modport sink   (input valid, input cam_phase_mode, output ready);
endinterface

@@ src/missing_tooth_crank_cam_sync.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// missing_tooth_crank_cam_sync
// Crank/cam sync decoder for a missing tooth trigger wheel.
// ----------------------------------------------------------------------------
// Usage:
//   tooth_in : one crank tooth event per transfer (interval, cam edge flag).
//   sync_out : one result per tooth (accepted, sync flags, position, lost).
//   cfg      : writes cam_phase_mode; always ready, write only while idle.
// Timing:
//   A tooth is captured in an input register, decoded through one pass of
//   compare and counter logic, and the result lands in the output register.
//   The result is offered on sync_out from the output register, behind the
//   input register. One tooth per cycle is sustained while sync_out is ready;
//   the decoder state register closes the only loop.
// Reset:
//   rst clears interval history, sync state, counters, the mode register and
//   both pipeline stages.
// Stall:
//   While sync_out is held, the input register still takes one tooth; after
//   that tooth_in.ready drops until the output register frees up.
// ----------------------------------------------------------------------------
module missing_tooth_crank_cam_sync #(
  parameter int TEETH_PER_REV = mtcs_pkg::TEETH_PER_REV_DEF,
  parameter int TEETH_TO_LOCK = mtcs_pkg::TEETH_TO_LOCK_DEF
) (
  input logic    clk,
  input logic    rst,
  tooth_if.sink  tooth_in,
  sync_if.source sync_out,
  cfg_if.sink    cfg
);

  logic              cam_phase_mode;
  logic              in_valid;
  mtcs_pkg::tooth_t  in_item;
  logic              out_valid;
  mtcs_pkg::result_t out_item;
  mtcs_pkg::result_t step_res;
  logic              advance;

  // Decode fires when an item is held and the output slot is free
  assign advance        = in_valid && (!out_valid || sync_out.ready);
  assign tooth_in.ready = !in_valid || advance;
  assign cfg.ready      = 1'b1;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_phase_mode <= 1'b0;
    end else if (cfg.valid) begin
      cam_phase_mode <= cfg.cam_phase_mode;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tooth_in.ready) begin
      in_valid <= tooth_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tooth_in.valid && tooth_in.ready) begin
      in_item.tooth_interval <= tooth_in.tooth_interval;
      in_item.cam_edge       <= tooth_in.cam_edge;
    end
  end

  mtcs_step #(
    .TEETH_PER_REV (TEETH_PER_REV),
    .TEETH_TO_LOCK (TEETH_TO_LOCK)
  ) u_step (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (in_item),
    .cam_mode (cam_phase_mode),
    .res      (step_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || sync_out.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_res;
    end
  end

  assign sync_out.valid          = out_valid;
  assign sync_out.tooth_accepted = out_item.tooth_accepted;
  assign sync_out.is_synced      = out_item.is_synced;
  assign sync_out.is_semi_synced = out_item.is_semi_synced;
  assign sync_out.tooth_position = out_item.tooth_position;
  assign sync_out.sync_lost      = out_item.sync_lost;

  // Checks
  a_one_sync_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.is_synced && out_item.is_semi_synced))
    else $error("synced and semi-synced together");

  a_lost_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.sync_lost) |->
      (!out_item.is_synced && !out_item.is_semi_synced && out_item.tooth_position == '0))
    else $error("sync loss left state behind");

  a_accept_synced: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.tooth_accepted) |-> (out_item.is_synced && !out_item.sync_lost))
    else $error("tooth accepted without sync");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !tooth_in.ready |-> (in_valid && out_valid && !sync_out.ready))
    else $error("input stalled with free slot");

endmodule

@@ src/mtcs_gap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_gap
// Interval compares: long gap detection and overlong tooth detection.
// ----------------------------------------------------------------------------
module mtcs_gap (
  input  logic [mtcs_pkg::IVL_W-1:0] cur,
  input  logic [mtcs_pkg::IVL_W-1:0] last,
  input  logic [mtcs_pkg::IVL_W-1:0] last1,
  output mtcs_pkg::gap_flags_t       flags
);

  logic [mtcs_pkg::IVL_W:0] cur_x2;
  logic [mtcs_pkg::IVL_W:0] last_x2;

  // Doubling at one extra bit never overflows
  assign cur_x2  = {cur, 1'b0};
  assign last_x2 = {last, 1'b0};

  assign flags.all_valid = (cur != '0) && (last != '0) && (last1 != '0);
  assign flags.gap       = ({1'b0, last} > cur_x2) && (last1 <= last);
  assign flags.overrun   = ({1'b0, cur} > last_x2);

endmodule

@@ src/mtcs_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_step
// Decoder state and its per-tooth update. The result reflects the state
// after the tooth presented on item; state moves when step is high.
// ----------------------------------------------------------------------------
module mtcs_step #(
  parameter int TEETH_PER_REV = mtcs_pkg::TEETH_PER_REV_DEF,
  parameter int TEETH_TO_LOCK = mtcs_pkg::TEETH_TO_LOCK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mtcs_pkg::tooth_t  item,
  input  logic              cam_mode,
  output mtcs_pkg::result_t res
);

  localparam int CW = mtcs_pkg::CNT_W;
  localparam int AW = mtcs_pkg::CAM_W;
  localparam logic [CW-1:0] LOCK_CNT  = CW'(TEETH_TO_LOCK);
  localparam logic [CW-1:0] CAM_START = CW'(TEETH_PER_REV + 1);
  localparam logic [CW:0]   REV_1     = (CW + 1)'(TEETH_PER_REV);
  localparam logic [CW:0]   REV_2     = (CW + 1)'(2 * TEETH_PER_REV);
  localparam logic [AW-1:0] CAM_ONE   = AW'(1);
  localparam logic [AW-1:0] CAM_TWO   = AW'(2);

  // State registers
  logic [mtcs_pkg::IVL_W-1:0] previous_interval;
  logic [mtcs_pkg::IVL_W-1:0] older_interval;
  mtcs_pkg::sync_state_t      state;
  mtcs_pkg::sync_state_t      state_next;
  logic [CW-1:0]              tooth_counter;
  logic [CW-1:0]              tooth_counter_next;
  logic [AW-1:0]              cam_pulse_count;
  logic [AW-1:0]              cam_pulse_count_next;

  mtcs_pkg::gap_flags_t flags;
  logic [CW-1:0] cnt_inc;
  logic [CW:0]   wrap_len;
  logic [AW-1:0] cam_inc;
  logic          gap_ok;
  logic          at_lock;
  logic          lock_ok;
  logic          drop;
  logic          accepted;

  mtcs_gap u_gap (
    .cur   (item.tooth_interval),
    .last  (previous_interval),
    .last1 (older_interval),
    .flags (flags)
  );

  // Shared terms
  assign cnt_inc  = tooth_counter + CW'(1);
  assign cam_inc  = item.cam_edge ? cam_pulse_count + AW'(1) : cam_pulse_count;
  assign wrap_len = cam_mode ? REV_2 : REV_1;
  assign gap_ok   = flags.all_valid && flags.gap;
  assign at_lock  = gap_ok && (cnt_inc == LOCK_CNT);
  assign lock_ok  = !cam_mode || (cam_inc == CAM_ONE) || (cam_inc == CAM_TWO);
  assign drop     = (({1'b0, cnt_inc} == REV_1) || ({1'b0, cnt_inc} == REV_2))
                    && flags.overrun;

  // Next sync state
  always_comb begin
    state_next = state;
    unique case (state)
      mtcs_pkg::SYNC_NONE: begin
        if (gap_ok) state_next = mtcs_pkg::SYNC_PARTIAL;
      end
      mtcs_pkg::SYNC_PARTIAL: begin
        if (at_lock && lock_ok) state_next = mtcs_pkg::SYNC_FULL;
      end
      mtcs_pkg::SYNC_FULL: begin
        if (drop) state_next = mtcs_pkg::SYNC_NONE;
      end
      default: state_next = mtcs_pkg::SYNC_NONE;
    endcase
  end

  // Counters and flags per state
  always_comb begin
    tooth_counter_next   = tooth_counter;
    cam_pulse_count_next = cam_inc;
    accepted             = 1'b0;
    unique case (state)
      mtcs_pkg::SYNC_NONE: begin
        if (gap_ok) begin
          tooth_counter_next   = '0;
          cam_pulse_count_next = '0;
        end
      end
      mtcs_pkg::SYNC_PARTIAL: begin
        if (flags.all_valid) begin
          tooth_counter_next = cnt_inc;
          if (at_lock && lock_ok) begin
            tooth_counter_next = (cam_mode && cam_inc == CAM_ONE) ? CAM_START : CW'(1);
          end else if (gap_ok) begin
            tooth_counter_next   = '0;
            cam_pulse_count_next = '0;
          end
        end
      end
      mtcs_pkg::SYNC_FULL: begin
        if (drop) begin
          tooth_counter_next   = '0;
          cam_pulse_count_next = '0;
        end else begin
          tooth_counter_next = ({1'b0, cnt_inc} >= wrap_len) ? '0 : cnt_inc;
          accepted           = 1'b1;
        end
      end
      default: begin
        tooth_counter_next   = '0;
        cam_pulse_count_next = '0;
      end
    endcase
  end

  // Result from the post-step state
  assign res.tooth_accepted = accepted;
  assign res.is_synced      = (state_next == mtcs_pkg::SYNC_FULL);
  assign res.is_semi_synced = (state_next == mtcs_pkg::SYNC_PARTIAL);
  assign res.tooth_position = tooth_counter_next;
  assign res.sync_lost      = (state == mtcs_pkg::SYNC_FULL) && drop;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_interval <= '0;
      older_interval    <= '0;
      state             <= mtcs_pkg::SYNC_NONE;
      tooth_counter     <= '0;
      cam_pulse_count   <= '0;
    end else if (step) begin
      previous_interval <= item.tooth_interval;
      older_interval    <= previous_interval;
      state             <= state_next;
      tooth_counter     <= tooth_counter_next;
      cam_pulse_count   <= cam_pulse_count_next;
    end
  end

endmodule
